>>> rtl/core/iidl_pkg.sv
// shared types and constants for the indexed insert/delete list
package iidl_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 8;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ADD_AT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_AT   = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_GET,
		ACT_INS,
		ACT_DEL
	} act_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOVE,
		S_FINISH,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic step;
		logic finish;
		logic load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic move_done;
		logic rsp_valid;
	} dp_sts_t;

endpackage

>>> rtl/core/iidl_ctrl.sv
// controller state machine for the indexed insert/delete list
module iidl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                rsp_stall,
	input  iidl_pkg::dp_sts_t   sts,
	output iidl_pkg::dp_cmd_t   cmd_o
);

	iidl_pkg::state_t state_q;
	iidl_pkg::state_t state_d;
	logic             rsp_free;

	assign rsp_free = !sts.rsp_valid || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iidl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iidl_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = iidl_pkg::S_MOVE;
				end
			end
			iidl_pkg::S_MOVE: begin
				if (sts.move_done) begin
					state_d = iidl_pkg::S_FINISH;
				end
			end
			iidl_pkg::S_FINISH: begin
				state_d = iidl_pkg::S_RESP;
			end
			iidl_pkg::S_RESP: begin
				if (rsp_free) begin
					state_d = iidl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = iidl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_o        = '0;
		req_stall    = 1'b1;
		unique case (state_q)
			iidl_pkg::S_IDLE: begin
				req_stall    = 1'b0;
				cmd_o.latch  = req_valid;
			end
			iidl_pkg::S_MOVE: begin
				cmd_o.step   = 1'b1;
			end
			iidl_pkg::S_FINISH: begin
				cmd_o.finish = 1'b1;
			end
			iidl_pkg::S_RESP: begin
				cmd_o.load   = rsp_free;
			end
			default: begin
				req_stall    = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/core/iidl_dp.sv
// datapath for the indexed insert/delete list: storage, shift engine, result register
module iidl_dp #(
	parameter int CAPACITY = 64,
	parameter int CNT_W    = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  iidl_pkg::dp_cmd_t                   cmd_i,
	output iidl_pkg::dp_sts_t                   sts,
	input  logic [iidl_pkg::CMD_W-1:0]          cmd,
	input  logic [iidl_pkg::POS_W-1:0]          position,
	input  logic signed [iidl_pkg::DATA_W-1:0]  value,
	input  logic                                rsp_stall,
	output logic                                rsp_valid,
	output logic signed [iidl_pkg::DATA_W-1:0]  read_value,
	output logic [iidl_pkg::STAT_W-1:0]         status,
	output logic [CNT_W-1:0]                    entry_count
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IDX_W = (CNT_W > iidl_pkg::POS_W) ? CNT_W : iidl_pkg::POS_W;

	logic [iidl_pkg::DATA_W-1:0] mem [CAPACITY];
	logic [iidl_pkg::DATA_W-1:0] rd_data_q;

	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             mv_q;
	logic                         pend_q;
	iidl_pkg::act_t               act_q;
	logic                         rsp_valid_q;
	logic [CNT_W-1:0]             pos_q;
	logic [CNT_W-1:0]             src_q;
	logic [CNT_W-1:0]             dst_q;
	logic [iidl_pkg::DATA_W-1:0]  val_q;
	logic [iidl_pkg::STAT_W-1:0]  st_q;
	logic [iidl_pkg::DATA_W-1:0]  read_value_q;
	logic [iidl_pkg::STAT_W-1:0]  status_q;
	logic [CNT_W-1:0]             entry_count_q;

	// request decode
	logic [IDX_W-1:0]             cnt_x;
	logic [IDX_W-1:0]             pos_x;
	logic [IDX_W-1:0]             ins_x;
	logic                         full;
	iidl_pkg::act_t               act_d;
	logic [iidl_pkg::STAT_W-1:0]  st_d;
	logic [CNT_W-1:0]             mv_d;
	logic [CNT_W-1:0]             src_d;
	logic [CNT_W-1:0]             pos_d;

	// memory port
	logic                         move_rd;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [iidl_pkg::DATA_W-1:0]  wr_data;

	always_comb begin
		cnt_x = IDX_W'(count_q);
		pos_x = IDX_W'(position);
		full  = (count_q == CNT_W'(CAPACITY));
		ins_x = pos_x;
		act_d = iidl_pkg::ACT_NONE;
		st_d  = iidl_pkg::STAT_DONE;
		unique case (cmd)
			iidl_pkg::CMD_GET: begin
				if (pos_x < cnt_x) begin
					act_d = iidl_pkg::ACT_GET;
				end else begin
					st_d  = iidl_pkg::STAT_RANGE;
				end
			end
			iidl_pkg::CMD_ADD_HEAD, iidl_pkg::CMD_ADD_TAIL, iidl_pkg::CMD_ADD_AT: begin
				if (cmd == iidl_pkg::CMD_ADD_HEAD) begin
					ins_x = '0;
				end else if (cmd == iidl_pkg::CMD_ADD_TAIL) begin
					ins_x = cnt_x;
				end
				// range check wins over the full check
				if (ins_x > cnt_x) begin
					st_d  = iidl_pkg::STAT_RANGE;
				end else if (full) begin
					st_d  = iidl_pkg::STAT_FULL;
				end else begin
					act_d = iidl_pkg::ACT_INS;
				end
			end
			iidl_pkg::CMD_DEL_AT: begin
				if (pos_x < cnt_x) begin
					act_d = iidl_pkg::ACT_DEL;
				end else begin
					st_d  = iidl_pkg::STAT_RANGE;
				end
			end
			default: begin
				act_d = iidl_pkg::ACT_NONE;
			end
		endcase
	end

	always_comb begin
		pos_d = CNT_W'(ins_x);
		mv_d  = '0;
		src_d = '0;
		unique case (act_d)
			iidl_pkg::ACT_INS: begin
				mv_d  = count_q - CNT_W'(ins_x);
				src_d = count_q - CNT_W'(1);
			end
			iidl_pkg::ACT_DEL: begin
				mv_d  = count_q - CNT_W'(pos_x) - CNT_W'(1);
				src_d = CNT_W'(pos_x) + CNT_W'(1);
			end
			default: begin
				mv_d  = '0;
			end
		endcase
	end

	// one read and one write per cycle; a moved entry is written the cycle after its read
	always_comb begin
		move_rd = cmd_i.step && (mv_q != '0);
		rd_en   = move_rd || (cmd_i.finish && (act_q == iidl_pkg::ACT_GET));
		rd_addr = cmd_i.finish ? pos_q[AW-1:0] : src_q[AW-1:0];
		wr_en   = (cmd_i.step && pend_q) || (cmd_i.finish && (act_q == iidl_pkg::ACT_INS));
		wr_addr = cmd_i.finish ? pos_q[AW-1:0] : dst_q[AW-1:0];
		wr_data = cmd_i.finish ? val_q : rd_data_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mv_q        <= '0;
			pend_q      <= 1'b0;
			act_q       <= iidl_pkg::ACT_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_i.latch) begin
				act_q  <= act_d;
				mv_q   <= mv_d;
				pend_q <= 1'b0;
			end else if (cmd_i.step) begin
				pend_q <= move_rd;
				if (move_rd) begin
					mv_q <= mv_q - CNT_W'(1);
				end
			end
			if (cmd_i.finish) begin
				if (act_q == iidl_pkg::ACT_INS) begin
					count_q <= count_q + CNT_W'(1);
				end else if (act_q == iidl_pkg::ACT_DEL) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (cmd_i.load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.latch) begin
			pos_q <= pos_d;
			val_q <= value;
			st_q  <= st_d;
			src_q <= src_d;
		end else if (move_rd) begin
			if (act_q == iidl_pkg::ACT_INS) begin
				dst_q <= src_q + CNT_W'(1);
				src_q <= src_q - CNT_W'(1);
			end else begin
				dst_q <= src_q - CNT_W'(1);
				src_q <= src_q + CNT_W'(1);
			end
		end
		if (cmd_i.load) begin
			read_value_q  <= (act_q == iidl_pkg::ACT_GET) ? rd_data_q : '0;
			status_q      <= st_q;
			entry_count_q <= count_q;
		end
	end

	assign sts.move_done = (mv_q == '0) && !pend_q;
	assign sts.rsp_valid = rsp_valid_q;
	assign rsp_valid     = rsp_valid_q;
	assign read_value    = read_value_q;
	assign status        = status_q;
	assign entry_count   = entry_count_q;

endmodule

>>> rtl/core/indexed_insert_delete_list.sv
// top level of the indexed insert/delete list
// Ordered list of up to CAPACITY signed 32-bit values kept in a single-port-write,
// single-port-read memory with a fill count. Each request (get, add at head, add at
// tail, add at position, delete at position) gives exactly one response carrying the
// value read, a status (done, position out of range, list full) and the entry count
// after the request. Inserts and deletes move the later entries one slot at a time
// through the memory's read and write ports, each moved entry written in the cycle
// after its read. No entry moves for a get, a failed request, an append or a delete
// of the last entry; otherwise at most the entry count of entries move. One request
// is in progress at a time; a finished response waits in the output register and
// does not block acceptance of the next request, but that next one holds in its
// response step until the waiting response is taken. Entries are never read before
// they are written, so the memory needs no clearing after reset.
module indexed_insert_delete_list #(
	parameter int CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [iidl_pkg::CMD_W-1:0]          cmd,
	input  logic [iidl_pkg::POS_W-1:0]          position,
	input  logic signed [iidl_pkg::DATA_W-1:0]  value,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic signed [iidl_pkg::DATA_W-1:0]  read_value,
	output logic [iidl_pkg::STAT_W-1:0]         status,
	output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

	// count must reach CAPACITY itself
	localparam int CNT_W = $clog2(CAPACITY + 1);

	iidl_pkg::dp_cmd_t dp_cmd;
	iidl_pkg::dp_sts_t dp_sts;

	// sequencer: accept, shift, finish, respond
	iidl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_stall (rsp_stall),
		.sts       (dp_sts),
		.cmd_o     (dp_cmd)
	);

	// storage, count, shift pointers and response register
	iidl_dp #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_i       (dp_cmd),
		.sts         (dp_sts),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule

>>> rtl/core/iidl_chk.sv
// port-level checks for the indexed insert/delete list, bound to the top level
module iidl_chk #(
	parameter int CAPACITY = 64
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_stall,
	input logic                                rsp_valid,
	input logic                                rsp_stall,
	input logic signed [iidl_pkg::DATA_W-1:0]  read_value,
	input logic [iidl_pkg::STAT_W-1:0]         status,
	input logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// a request in progress blocks the next one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one still in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == iidl_pkg::STAT_DONE) || (status == iidl_pkg::STAT_RANGE)
			|| (status == iidl_pkg::STAT_FULL))
		else $error("undefined status code");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_fail_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != iidl_pkg::STAT_DONE) |-> read_value == '0)
		else $error("failed request returned a nonzero value");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(status)
			&& $stable(entry_count))
		else $error("stalled response changed");

endmodule

bind indexed_insert_delete_list iidl_chk #(.CAPACITY(CAPACITY)) u_iidl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.read_value  (read_value),
	.status      (status),
	.entry_count (entry_count)
);

>>> dv/list_checker.sv
// checker that predicts and compares every response of the indexed insert/delete list
module list_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic [iidl_pkg::CMD_W-1:0]          cmd,
	input  logic [iidl_pkg::POS_W-1:0]          position,
	input  logic signed [iidl_pkg::DATA_W-1:0]  value,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic signed [iidl_pkg::DATA_W-1:0]  read_value,
	input  logic [iidl_pkg::STAT_W-1:0]         status,
	input  logic [$clog2(CAPACITY+1)-1:0]       entry_count,
	output int                                  outstanding,
	output int                                  mismatches
);

	import iidl_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY+1);

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STAT_W-1:0]        status;
		logic [CNT_W-1:0]         entry_count;
	} list_rsp_t;

	logic signed [DATA_W-1:0] list_entries [CAPACITY];
	int unsigned              list_count;
	list_rsp_t                expected_rsp_q [$];
	list_rsp_t                oldest_rsp;
	int                       mismatch_total = 0;

	assign mismatches = mismatch_total;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_total++;
	endtask

	// insert with the range check ahead of the full check
	function automatic logic [STAT_W-1:0] insert_entry(input int unsigned at,
			input logic signed [DATA_W-1:0] val);
		int unsigned i;
		if (at > list_count)
			return STAT_RANGE;
		if (list_count >= CAPACITY)
			return STAT_FULL;
		for (i = list_count; i > at; i--)
			list_entries[i] = list_entries[i-1];
		list_entries[at] = val;
		list_count++;
		return STAT_DONE;
	endfunction

	function automatic list_rsp_t apply_list_request(input logic [CMD_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_rsp_t   rsp;
		int unsigned i;
		rsp.read_value = '0;
		rsp.status = STAT_DONE;
		case (op)
			CMD_GET: begin
				if (pos < list_count)
					rsp.read_value = list_entries[pos];
				else
					rsp.status = STAT_RANGE;
			end
			CMD_ADD_HEAD: rsp.status = insert_entry(0, val);
			CMD_ADD_TAIL: rsp.status = insert_entry(list_count, val);
			CMD_ADD_AT:   rsp.status = insert_entry(pos, val);
			CMD_DEL_AT: begin
				if (pos < list_count) begin
					for (i = pos; i + 1 < list_count; i++)
						list_entries[i] = list_entries[i+1];
					list_count--;
				end else begin
					rsp.status = STAT_RANGE;
				end
			end
			default: ;
		endcase
		rsp.entry_count = CNT_W'(list_count);
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count = 0;
			expected_rsp_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("response with no request waiting");
				end else begin
					oldest_rsp = expected_rsp_q.pop_front();
					if (read_value !== oldest_rsp.read_value)
						report_mismatch($sformatf("read_value %0d, expected %0d",
							read_value, oldest_rsp.read_value));
					if (status !== oldest_rsp.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, oldest_rsp.status));
					if (entry_count !== oldest_rsp.entry_count)
						report_mismatch($sformatf("entry_count %0d, expected %0d",
							entry_count, oldest_rsp.entry_count));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q.push_back(apply_list_request(cmd, position, value));
			outstanding <= expected_rsp_q.size();
		end
	end

endmodule

>>> dv/tb_indexed_insert_delete_list.sv
// testbench top for the indexed insert/delete list: stimulus, idling and verdict
module tb_indexed_insert_delete_list;

	import iidl_pkg::*;

	localparam int CAPACITY   = 64;
	localparam int CNT_W      = $clog2(CAPACITY+1);
	localparam int LONG_HOLD  = 300;
	localparam int END_SETTLE = 80;

	// codes the block ignores
	localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

	// mix of commands used by a random stretch
	localparam int MIX_BALANCED = 0;
	localparam int MIX_GROW     = 1;
	localparam int MIX_SHRINK   = 2;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [CMD_W-1:0]         cmd = CMD_GET;
	logic [POS_W-1:0]         position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic [STAT_W-1:0]        status;
	logic [CNT_W-1:0]         entry_count;

	int outstanding;
	int mismatches;

	// stimulus bookkeeping: entry count as the sender expects it, used to aim positions
	int fill_level = 0;
	// last stretch of the run: no idling on either side
	bit calm_tail = 1'b0;
	// asks the receiver for one long hold-off
	bit long_hold_go = 1'b0;
	// set by the receiver once the long hold-off has run
	bit long_hold_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	indexed_insert_delete_list #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.position   (position),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.status     (status),
		.entry_count(entry_count)
	);

	list_checker #(
		.CAPACITY(CAPACITY)
	) u_list_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.position   (position),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.status     (status),
		.entry_count(entry_count),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	// offer one request and hold it until the block takes it; always entered at a rising edge
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
			input logic signed [DATA_W-1:0] v);
		req_valid <= 1'b1;
		cmd <= c;
		position <= p;
		value <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// track the count the same way the list does, only to aim later positions
		case (c)
			CMD_ADD_HEAD, CMD_ADD_TAIL: begin
				if (fill_level < CAPACITY)
					fill_level++;
			end
			CMD_ADD_AT: begin
				if (p <= fill_level && fill_level < CAPACITY)
					fill_level++;
			end
			CMD_DEL_AT: begin
				if (p < fill_level)
					fill_level--;
			end
			default: ;
		endcase
		// random gap after the request, valid dropped for the whole burst
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
	endtask

	// stop offering and wait until every response has come back
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// one random request, command mix picked by the stretch it belongs to
	task automatic send_random_request(input int mix);
		int                       roll;
		int                       add_pct;
		logic [CMD_W-1:0]         c;
		logic [POS_W-1:0]         p;
		logic signed [DATA_W-1:0] v;
		add_pct = (mix == MIX_GROW) ? 55 : (mix == MIX_SHRINK) ? 12 : 38;
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			case ($urandom_range(0, 2))
				0:       c = CMD_RSVD_A;
				1:       c = CMD_RSVD_B;
				default: c = CMD_RSVD_C;
			endcase
		end else if (roll < 23) begin
			c = CMD_GET;
		end else if (roll < 23 + add_pct) begin
			case ($urandom_range(0, 2))
				0:       c = CMD_ADD_HEAD;
				1:       c = CMD_ADD_TAIL;
				default: c = CMD_ADD_AT;
			endcase
		end else begin
			c = CMD_DEL_AT;
		end
		// positions mostly inside the list, some at the boundary, some anywhere
		case ($urandom_range(0, 9))
			0:       p = POS_W'($urandom_range(0, 255));
			1:       p = POS_W'(fill_level);
			2:       p = POS_W'(fill_level + 1);
			default: p = POS_W'($urandom_range(0, fill_level));
		endcase
		case ($urandom_range(0, 15))
			0:       v = 32'sh7fff_ffff;
			1:       v = 32'sh8000_0000;
			2:       v = '0;
			3:       v = -32'sd1;
			default: v = $urandom;
		endcase
		send_request(c, p, v);
	endtask

	task automatic run_stretch(input int n, input int mix);
		repeat (n)
			send_random_request(mix);
	endtask

	// receiver: random stall bursts, one long hold-off on request, none in the calm tail
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_go && !long_hold_done) begin
				// long hold-off so the output register and the block both fill
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD)
					@(posedge clk);
				rsp_stall <= 1'b0;
				long_hold_done = 1'b1;
			end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 18))
					@(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// sender and verdict
	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list corner cases
		send_request(CMD_GET, 8'd0, 32'sd11);
		send_request(CMD_DEL_AT, 8'd0, 32'sd12);
		send_request(CMD_ADD_AT, 8'd1, 32'sd13);
		// append on an empty list by position, then head and tail with extreme values
		send_request(CMD_ADD_AT, 8'd0, 32'sh7fff_ffff);
		send_request(CMD_ADD_HEAD, 8'd0, 32'sh8000_0000);
		send_request(CMD_ADD_TAIL, 8'd0, 32'sd0);
		send_request(CMD_ADD_AT, 8'd1, -32'sd1);
		// position equal to the count appends, far past the end is rejected
		send_request(CMD_ADD_AT, 8'd4, 32'sh1234_5678);
		send_request(CMD_ADD_AT, 8'd255, 32'sh0bad_cafe);
		// reads at first, last, one past the end and the top of the position range
		send_request(CMD_GET, 8'd0, 32'sd0);
		send_request(CMD_GET, 8'd4, 32'sd0);
		send_request(CMD_GET, 8'd5, 32'sd0);
		send_request(CMD_GET, 8'd255, 32'sd0);
		// deletes in the middle, at the end and out of range
		send_request(CMD_DEL_AT, 8'd2, 32'sd0);
		send_request(CMD_DEL_AT, 8'd3, 32'sd0);
		send_request(CMD_DEL_AT, 8'd255, 32'sd0);
		// ignored codes with payload that must not leak
		send_request(CMD_RSVD_A, 8'd0, -32'sd1);
		send_request(CMD_RSVD_B, 8'd255, 32'sh7fff_ffff);
		send_request(CMD_RSVD_C, 8'd1, 32'sh8000_0000);
		send_request(CMD_GET, 8'd1, 32'sd0);
		send_request(CMD_DEL_AT, 8'd0, 32'sd0);
		send_request(CMD_GET, 8'd0, 32'sd0);

		// random: balanced warm-up
		run_stretch(120, MIX_BALANCED);

		// grow toward full while the receiver holds off for a long stretch
		long_hold_go = 1'b1;
		run_stretch(120, MIX_GROW);
		while (fill_level < CAPACITY)
			send_request(CMD_ADD_TAIL, 8'd0, $urandom);
		// full list: range check wins past the end, otherwise full is reported
		send_request(CMD_ADD_AT, POS_W'(CAPACITY + 1), $urandom);
		send_request(CMD_ADD_AT, POS_W'(CAPACITY), $urandom);
		send_request(CMD_ADD_HEAD, 8'd0, $urandom);
		run_stretch(60, MIX_GROW);

		// shrink down to empty and keep hitting the empty list
		run_stretch(120, MIX_SHRINK);

		// sender pause until the block has answered everything
		wait_for_drain();
		@(posedge clk);

		run_stretch(70, MIX_BALANCED);

		// calm tail: back-to-back requests and no receiver stalls
		calm_tail = 1'b1;
		run_stretch(60, MIX_BALANCED);

		wait_for_drain();
		repeat (END_SETTLE)
			@(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// run limit, well above the slowest legal run
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/iidl_pkg.sv
rtl/core/iidl_ctrl.sv
rtl/core/iidl_dp.sv
rtl/core/indexed_insert_delete_list.sv
rtl/core/iidl_chk.sv
dv/list_checker.sv
dv/tb_indexed_insert_delete_list.sv
